// ===== hw/rtl/fmpa_pkg.sv =====
// Shared types, codes and helpers for the first-match prefix access list.
`timescale 1ns / 1ps

package fmpa_pkg;

  // Table size default and fixed field widths
  localparam int unsigned RULE_COUNT_DEF = 128;
  localparam int unsigned SLOT_W         = 7;
  localparam int unsigned HIT_W          = 8;
  localparam int unsigned PLEN_W         = 8;
  localparam int unsigned ADDR_W         = 64;

  // Operation codes of an input word
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Rule action codes
  localparam logic [1:0] ACT_DENY   = 2'd0;
  localparam logic [1:0] ACT_PERMIT = 2'd1;
  localparam logic [1:0] ACT_UNSET  = 2'd2;

  // Family codes and prefix limits
  localparam logic             FAM_V4     = 1'b0;
  localparam logic [PLEN_W-1:0] PLEN_V4_MAX = 8'd32;
  localparam logic [PLEN_W-1:0] PLEN_V6_MAX = 8'd128;

  // Slot code for default deny and load acknowledgements
  localparam logic [HIT_W-1:0] NO_HIT = 8'd128;

  // Rule write broadcast to every cell
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        action;
    logic              fam;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
  } wr_t;

  // Client address held for the search
  typedef struct packed {
    logic              fam;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
  } qry_t;

  // Search token passed from cell to cell
  typedef struct packed {
    logic             vld;
    logic             done;
    logic             permit;
    logic             dflt;
    logic [HIT_W-1:0] hit;
  } tok_t;

  // Care mask over {hi, lo}: top plen bits of a 32-bit or 128-bit address
  function automatic logic [2*ADDR_W-1:0] prefix_mask(logic fam, logic [PLEN_W-1:0] plen);
    logic [2*ADDR_W-1:0] m;
    logic [8:0]          base;
    base = (fam == FAM_V4) ? 9'd32 : 9'd128;
    for (int j = 0; j < 2 * ADDR_W; j++) begin
      m[j] = (9'(j) < base) && ((9'(j) + {1'b0, plen}) >= base);
    end
    return m;
  endfunction

endpackage

// ===== hw/rtl/fmpa_if.sv =====
// Valid/ready channel interfaces for input words and result words.
`timescale 1ns / 1ps

interface fmpa_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [6:0]  rule_slot;
  logic [1:0]  rule_action;
  logic        family_v6;
  logic [7:0]  prefix_len;
  logic [63:0] addr_high;
  logic [63:0] addr_low;

  modport source (
    output valid, func, rule_slot, rule_action, family_v6, prefix_len, addr_high, addr_low,
    input  ready
  );
  modport sink (
    input  valid, func, rule_slot, rule_action, family_v6, prefix_len, addr_high, addr_low,
    output ready
  );
endinterface

interface fmpa_out_if;
  logic       valid;
  logic       ready;
  logic       permitted;
  logic [7:0] hit_slot;
  logic       default_deny;

  modport source (
    output valid, permitted, hit_slot, default_deny,
    input  ready
  );
  modport sink (
    input  valid, permitted, hit_slot, default_deny,
    output ready
  );
endinterface

// ===== hw/rtl/fmpa_cell.sv =====
// One rule cell: holds a rule and advances the search token by one slot.
`timescale 1ns / 1ps

module fmpa_cell
  import fmpa_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  wr_t  wr_i,
  input  qry_t qry_i,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic [1:0]          act_q;
  logic                fam_q;
  logic [PLEN_W-1:0]   plen_q;
  logic [ADDR_W-1:0]   hi_q;
  logic [ADDR_W-1:0]   lo_q;
  logic [2*ADDR_W-1:0] mask;
  logic                match;
  logic                wr_sel;
  tok_t                tok_d;
  tok_t                tok_q;

  assign wr_sel = wr_i.en && (int'(wr_i.slot) == int'(IDX));

  // Hold the rule action; reset marks the slot unset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_UNSET;
    end else if (wr_sel) begin
      act_q <= wr_i.action;
    end
  end

  // Hold the rule address fields
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      fam_q  <= wr_i.fam;
      plen_q <= wr_i.plen;
      hi_q   <= wr_i.hi;
      lo_q   <= wr_i.lo;
    end
  end

  // Compare the client address under the rule prefix
  assign mask  = prefix_mask(fam_q, plen_q);
  assign match = (fam_q == qry_i.fam) &&
                 ((({hi_q, lo_q} ^ {qry_i.hi, qry_i.lo}) & mask) == '0);

  // Decide the token here if no earlier slot has
  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.done) begin
      if (act_q != ACT_DENY && act_q != ACT_PERMIT) begin
        tok_d.done   = 1'b1;
        tok_d.permit = 1'b0;
        tok_d.dflt   = 1'b1;
        tok_d.hit    = NO_HIT;
      end else if (match) begin
        tok_d.done   = 1'b1;
        tok_d.permit = (act_q == ACT_PERMIT);
        tok_d.dflt   = 1'b0;
        tok_d.hit    = HIT_W'(IDX);
      end
    end
  end

  // Advance the token to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== hw/rtl/first_match_prefix_acl_core.sv =====
// Top level of the first-match prefix access list: control, query hold and cell chain.
`timescale 1ns / 1ps

// Ordered first-match access list of address prefixes, one rule per cell in a chain
// of RULE_COUNT cells. A load word writes its rule into the addressed cell in the
// cycle it is accepted and its acknowledgement is in the output register on the next
// cycle. A check word launches a search token that walks the chain one cell per
// cycle while the client address is held for all cells; the first matching deny or
// permit rule, or the first unset rule, decides, and the answer passes from the launch
// register through the cell registers and the pending-result register to the output
// register. One check is in flight at a time, and a new word is taken once the check
// is done and the output register is free or being drained. After reset every slot
// is unset, so checks give default deny until rules are loaded.
module first_match_prefix_acl_core
  import fmpa_pkg::*;
#(
  parameter int unsigned RULE_COUNT = RULE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fmpa_in_if.sink           in_i,
  fmpa_out_if.source        out_o
);

  tok_t              tok [RULE_COUNT+1];
  logic [RULE_COUNT:0] tok_vld;
  tok_t              launch_q;
  tok_t              end_tok;
  qry_t              qry_q;
  qry_t              qry_n;
  wr_t               wr;
  logic              busy_q;
  logic              pend_vld_q;
  logic              pend_perm_q;
  logic [HIT_W-1:0]  pend_hit_q;
  logic              pend_dflt_q;
  logic              out_vld_q;
  logic              out_perm_q;
  logic [HIT_W-1:0]  out_hit_q;
  logic              out_dflt_q;
  logic              out_free;
  logic              in_acc;
  logic              load_acc;
  logic              check_acc;
  logic [PLEN_W-1:0] plen_lim;

  // Handshake
  assign out_free  = !out_vld_q || out_o.ready;
  assign in_i.ready = !busy_q && out_free;
  assign in_acc    = in_i.valid && in_i.ready;
  assign load_acc  = in_acc && (in_i.func == FUNC_LOAD);
  assign check_acc = in_acc && (in_i.func == FUNC_CHECK);

  // Drop the upper bits of an IPv4 address
  always_comb begin
    qry_n.fam = in_i.family_v6;
    qry_n.hi  = in_i.addr_high;
    qry_n.lo  = in_i.addr_low;
    if (in_i.family_v6 == FAM_V4) begin
      qry_n.hi = '0;
      qry_n.lo = {32'd0, in_i.addr_low[31:0]};
    end
  end

  // Build the rule write: clamp length, fold undefined action to unset
  assign plen_lim = (in_i.family_v6 == FAM_V4) ? PLEN_V4_MAX : PLEN_V6_MAX;
  always_comb begin
    wr.en     = load_acc;
    wr.slot   = in_i.rule_slot;
    wr.action = (in_i.rule_action == ACT_DENY || in_i.rule_action == ACT_PERMIT) ?
                in_i.rule_action : ACT_UNSET;
    wr.fam    = qry_n.fam;
    wr.plen   = (in_i.prefix_len > plen_lim) ? plen_lim : in_i.prefix_len;
    wr.hi     = qry_n.hi;
    wr.lo     = qry_n.lo;
  end

  // Hold the client address for the whole walk
  always_ff @(posedge clk_i) begin
    if (check_acc) begin
      qry_q <= qry_n;
    end
  end

  // Launch the search token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= '0;
    end else begin
      launch_q <= tok_t'{vld: check_acc, done: 1'b0, permit: 1'b0, dflt: 1'b0, hit: '0};
    end
  end

  // Cell chain
  assign tok[0] = launch_q;
  for (genvar i = 0; i < RULE_COUNT; i++) begin : g_cell
    fmpa_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .qry_i  (qry_q),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  for (genvar i = 0; i <= RULE_COUNT; i++) begin : g_vld
    assign tok_vld[i] = tok[i].vld;
  end

  // Resolve the token at the table end
  always_comb begin
    end_tok = tok[RULE_COUNT];
    if (!end_tok.done) begin
      end_tok.permit = 1'b0;
      end_tok.dflt   = 1'b1;
      end_tok.hit    = NO_HIT;
    end
  end

  // Track the check in flight and its pending result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      if (check_acc) begin
        busy_q <= 1'b1;
      end else if (pend_vld_q && out_free) begin
        busy_q <= 1'b0;
      end
      if (end_tok.vld) begin
        pend_vld_q <= 1'b1;
      end else if (out_free) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_tok.vld) begin
      pend_perm_q <= end_tok.permit;
      pend_hit_q  <= end_tok.hit;
      pend_dflt_q <= end_tok.dflt;
    end
  end

  // Output register: pending check result or load acknowledgement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= pend_vld_q || load_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_vld_q) begin
        out_perm_q <= pend_perm_q;
        out_hit_q  <= pend_hit_q;
        out_dflt_q <= pend_dflt_q;
      end else begin
        out_perm_q <= 1'b0;
        out_hit_q  <= NO_HIT;
        out_dflt_q <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.permitted    = out_perm_q;
  assign out_o.hit_slot     = out_hit_q;
  assign out_o.default_deny = out_dflt_q;

`ifndef ASSERT_OFF
  // At most one search token in the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_vld) <= 1)
    else $error("more than one search token in flight");

  // No rule write while a search is walking the chain
  a_no_wr_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (tok_vld == '0))
    else $error("rule write during search");

  // A finished search never overwrites a waiting result
  a_pend_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.vld |-> !pend_vld_q)
    else $error("pending result overwritten");

  // A pending result belongs to a check still marked busy
  a_pend_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_vld_q |-> busy_q)
    else $error("pending result without a check in flight");

  // Default deny carries the no-hit slot and no permit
  a_dflt_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_dflt_q) |-> (out_hit_q == NO_HIT && !out_perm_q))
    else $error("malformed default deny word");
`endif

endmodule
